[sv/iwn_pkg.sv]
// Package for the ISO 8601 week number block: transaction types, calendar
// constants and small arithmetic helpers. No dependencies.
package iwn_pkg;

   // Input transaction: a calendar date.
   typedef struct packed {
      logic [3:0]  month;
      logic [4:0]  day;
      logic [13:0] year;
   } req_type;

   // Result transaction: ISO week and ISO week-numbering year.
   typedef struct packed {
      logic [5:0]  week_number;
      logic [13:0] iso_year;
   } rsp_type;

   // Years are biased by 400 internally so that the running day count stays
   // positive; day count zero (January 1 of biased year 1) is a Monday.
   // The pipeline carries p = biased year - 1.
   localparam logic [14:0] YEAR_BIAS_M1   = 15'd399;
   localparam logic [14:0] YEAR_BIAS      = 15'd400;
   localparam logic [14:0] YEAR_BIAS_M2   = 15'd398;
   localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;

   // floor(p / 100) = (p * DIV100_MUL) >> DIV100_SHIFT, exact for p < 2^15.
   localparam logic [14:0] DIV100_MUL     = 15'd20972;
   localparam int          DIV100_SHIFT   = 21;
   localparam logic [14:0] HUNDRED        = 15'd100;

   // floor(n / 7) = (n * DIV7_MUL) >> DIV7_SHIFT, exact for n < 682.
   localparam logic [9:0]  DIV7_MUL       = 10'd586;
   localparam int          DIV7_SHIFT     = 12;

   // Days in the year before the first of the given month (1 = January).
   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // Remainder modulo 7 of a 15-bit value. Since 8 is 1 modulo 7, the octal
   // digits are summed, folded once more and corrected by one subtraction.
   function automatic logic [2:0] mod7(input logic [14:0] value);
      logic [5:0] digit_sum;
      logic [3:0] fold;
      logic [3:0] rem;
      digit_sum = {3'b0, value[14:12]} + {3'b0, value[11:9]} + {3'b0, value[8:6]}
                + {3'b0, value[5:3]} + {3'b0, value[2:0]};
      fold = {1'b0, digit_sum[5:3]} + {1'b0, digit_sum[2:0]};
      rem = (fold >= 4'd7) ? (fold - 4'd7) : fold;
      return rem[2:0];
   endfunction

endpackage

[sv/iso_week_number_top.sv]
// Top level of the ISO 8601 week number block: a five-register pipeline
// from calendar date to ISO week and ISO year. Depends on iwn_pkg.
//
// Use of the block:
// The request channel (req_valid, req_stall, req_data) carries one calendar
// date per transaction: month, day and year. A day past the end of its
// month rolls into the following month, month zero means December of the
// year before, and a month above twelve wraps into the year after.
// The response channel (rsp_valid, rsp_stall, rsp_data) returns one
// transaction per date, in order: the ISO week number (1 to 53) and the ISO
// week-numbering year, which wraps modulo 2^14 at the ends of the range.
//
// A date taken at a rising edge passes stages 1 to 4 and the output register
// before it appears on rsp_data. Throughput is one transaction per cycle
// while rsp_stall is low; the five register stages each hold one date, and
// the deepest is the constant multiply that divides the year by one hundred.
// Each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so bubbles close up and a stalled result does not stop
// new dates from entering while free stages remain. When the receiver
// holds rsp_stall, the result stays on rsp_data unchanged and the pipeline
// fills behind it; req_stall rises once all stages are occupied.
// A synchronous reset empties all stages; no transaction is lost or
// repeated by a stall, and nothing else in the block needs clearing.
module iso_week_number_top
   import iwn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Per-stage ready: the stage may load when empty or when it drains.
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // ---------------------------------------------------------------------
   // Stage 1: normalize the month and form p = biased year - 1, then
   // start the division by one hundred with a reciprocal multiply.
   // ---------------------------------------------------------------------
   logic [3:0]  month_n;
   logic [14:0] p_n;
   logic [29:0] prod100;

   always_comb begin
      if (req_data.month == 4'd0) begin
         month_n = 4'd12;
         p_n = {1'b0, req_data.year} + YEAR_BIAS_M2;
      end else if (req_data.month > 4'd12) begin
         month_n = req_data.month - 4'd12;
         p_n = {1'b0, req_data.year} + YEAR_BIAS;
      end else begin
         month_n = req_data.month;
         p_n = {1'b0, req_data.year} + YEAR_BIAS_M1;
      end
      prod100 = {15'b0, p_n} * {15'b0, DIV100_MUL};
   end

   logic        s1_valid_ff;
   logic [14:0] s1_p_ff;
   logic [3:0]  s1_month_ff;
   logic [4:0]  s1_day_ff;
   logic [7:0]  s1_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rdy1) begin
         s1_valid_ff <= req_valid;
      end
      if (rdy1) begin
         s1_p_ff     <= p_n;
         s1_month_ff <= month_n;
         s1_day_ff   <= req_data.day;
         s1_q_ff     <= prod100[DIV100_SHIFT+7:DIV100_SHIFT];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: leap-year flags for the year and the year before, weekday
   // offset of January 1, and the zero-based day of year.
   // ---------------------------------------------------------------------
   logic [14:0]       qx100;
   logic [6:0]        r100;
   logic              leap_cur_in;
   logic              leap_prev_in;
   logic [14:0]       jan1_in;
   logic signed [9:0] doy_in;

   always_comb begin
      qx100 = 15'({7'b0, s1_q_ff} * HUNDRED);
      r100 = 7'(s1_p_ff - qx100);
      // Year y = p + 1 is a leap year when p mod 4 is 3, unless y is a
      // century year that is not a multiple of 400.
      leap_cur_in = (s1_p_ff[1:0] == 2'd3) && ((r100 != 7'd99) || (s1_q_ff[1:0] == 2'd3));
      leap_prev_in = (s1_p_ff[1:0] == 2'd0) && ((r100 != 7'd0) || (s1_q_ff[1:0] == 2'd0));
      // 365 is 1 modulo 7, so only the leap-day terms matter for the weekday.
      jan1_in = s1_p_ff + (s1_p_ff >> 2) + {9'b0, s1_q_ff[7:2]} - {7'b0, s1_q_ff};
      doy_in = $signed({1'b0, days_before_month(s1_month_ff)})
             + $signed({9'b0, (leap_cur_in && (s1_month_ff > 4'd2))})
             + $signed({5'b0, s1_day_ff}) - 10'sd1;
   end

   logic              s2_valid_ff;
   logic [14:0]       s2_p_ff;
   logic [14:0]       s2_jan1_ff;
   logic signed [9:0] s2_doy_ff;
   logic              s2_leap_cur_ff;
   logic              s2_leap_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (rdy2) begin
         s2_p_ff         <= s1_p_ff;
         s2_jan1_ff      <= jan1_in;
         s2_doy_ff       <= doy_in;
         s2_leap_cur_ff  <= leap_cur_in;
         s2_leap_prev_ff <= leap_prev_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: weekday (0 = Monday) and the Thursday of the same week,
   // as an offset from January 1 of the current year.
   // ---------------------------------------------------------------------
   logic [14:0]       day_sum;
   logic [2:0]        weekday;
   logic signed [9:0] thu_in;

   always_comb begin
      day_sum = s2_jan1_ff + 15'(s2_doy_ff);
      weekday = mod7(day_sum);
      thu_in = s2_doy_ff + 10'sd3 - $signed({7'b0, weekday});
   end

   logic              s3_valid_ff;
   logic [14:0]       s3_p_ff;
   logic signed [9:0] s3_thu_ff;
   logic              s3_leap_cur_ff;
   logic              s3_leap_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (rdy3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (rdy3) begin
         s3_p_ff         <= s2_p_ff;
         s3_thu_ff       <= thu_in;
         s3_leap_cur_ff  <= s2_leap_cur_ff;
         s3_leap_prev_ff <= s2_leap_prev_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: the Thursday's calendar year is the ISO year; find the
   // Thursday's day of year within it.
   // ---------------------------------------------------------------------
   logic signed [9:0] year_len;
   logic signed [9:0] prev_len;
   logic signed [9:0] yday_s;
   logic [8:0]        yday_in;
   logic [14:0]       iso_full;

   always_comb begin
      year_len = $signed({1'b0, DAYS_PER_YEAR}) + $signed({9'b0, s3_leap_cur_ff});
      prev_len = $signed({1'b0, DAYS_PER_YEAR}) + $signed({9'b0, s3_leap_prev_ff});
      if (s3_thu_ff >= year_len) begin
         // Thursday falls in the next year.
         yday_s = s3_thu_ff - year_len;
         iso_full = s3_p_ff - YEAR_BIAS_M2;
      end else if (s3_thu_ff >= 10'sd0) begin
         yday_s = s3_thu_ff;
         iso_full = s3_p_ff - YEAR_BIAS_M1;
      end else begin
         // Thursday falls in the previous year.
         yday_s = s3_thu_ff + prev_len;
         iso_full = s3_p_ff - YEAR_BIAS;
      end
      yday_in = yday_s[8:0];
   end

   logic        s4_valid_ff;
   logic [8:0]  s4_yday_ff;
   logic [13:0] s4_iso_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (rdy4) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (rdy4) begin
         s4_yday_ff <= yday_in;
         s4_iso_ff  <= iso_full[13:0];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: week number = day of year / 7 + 1, into the output register.
   // ---------------------------------------------------------------------
   logic [18:0] prod7;
   rsp_type     rsp_in;

   always_comb begin
      prod7 = 19'({10'b0, s4_yday_ff} * {9'b0, DIV7_MUL});
      rsp_in.week_number = prod7[DIV7_SHIFT+5:DIV7_SHIFT] + 6'd1;
      rsp_in.iso_year = s4_iso_ff;
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy5) begin
         rsp_valid_ff <= s4_valid_ff;
      end
      if (rdy5) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // Flow control: each stage advances when it is empty or the next one
   // advances, so a stall at the output fills the bubbles first.
   always_comb begin
      rdy5 = !rsp_valid_ff || !rsp_stall;
      rdy4 = !s4_valid_ff || rdy5;
      rdy3 = !s3_valid_ff || rdy4;
      rdy2 = !s2_valid_ff || rdy3;
      rdy1 = !s1_valid_ff || rdy2;
   end

   assign req_stall = !rdy1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A held first stage keeps its date until the stage behind it frees up.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rdy2) |=> (s1_valid_ff && $stable(s1_p_ff) && $stable(s1_q_ff)))
      else $error("first stage lost or changed a held date");

   // The Thursday lies at most a few days outside the current year.
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> ((s3_thu_ff >= -10'sd6) && (s3_thu_ff <= 10'sd368)))
      else $error("Thursday offset out of range");

   // The day of year within the ISO year never exceeds the last day.
   assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (s4_yday_ff <= 9'd365))
      else $error("day of ISO year out of range");

   // Every delivered week number lies between 1 and 53.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.week_number >= 6'd1) &&
                        (rsp_data_ff.week_number <= 6'd53)))
      else $error("week number out of range");
`endif

endmodule

[sim/tb_iso_week_number_top.sv]
// Self-checking testbench for iso_week_number_top: dates go in on the request
// channel and each ISO week / ISO year result is checked against a predictor.
// Depends on iwn_pkg and iso_week_number_top.
module tb_iso_week_number_top;
   import iwn_pkg::*;

   // Days in a common year before the first of each month, January first.
   localparam int unsigned DAYS_AHEAD[12] = '{0, 31, 59, 90, 120, 151,
                                              181, 212, 243, 273, 304, 334};
   // Internal year bias: keeps the running day count positive even for
   // year zero with month zero, and makes day count zero a Monday.
   localparam int unsigned BIAS           = 400;
   localparam int          SHOWN_ERRORS   = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted results of accepted dates, oldest first.
   rsp_type pending_weeks[$];
   int      mismatches   = 0;
   // Longest idle stretch that each side may draw per transaction.
   int      tx_gap_max   = 14;
   int      rx_gap_max   = 14;
   // A request to the receiver for one long hold-off, in cycles.
   int      hold_cycles  = 0;

   iso_week_number_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Running day count of January 1 of a biased year.
   function automatic int unsigned jan1_day_count(input int unsigned biased_year);
      int unsigned p;
      p = biased_year - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   function automatic bit is_leap(input int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   // ISO week and ISO year of a date, after the same normalization that the
   // block applies: month zero and months above twelve shift the year, and
   // day zero or days past the month's end roll through the day count.
   function automatic rsp_type iso_week_of(input req_type date);
      int unsigned mon;
      int unsigned yr;
      int unsigned count;
      int unsigned thursday;
      int unsigned iso_yr;
      rsp_type     result;
      mon = date.month;
      yr  = date.year + BIAS;
      if (mon == 0) begin
         mon = 12;
         yr  = yr - 1;
      end else if (mon > 12) begin
         mon = mon - 12;
         yr  = yr + 1;
      end
      count = jan1_day_count(yr) + DAYS_AHEAD[mon - 1];
      if (mon > 2 && is_leap(yr)) begin
         count = count + 1;
      end
      count = count + date.day - 1;
      // The Thursday of the Monday-based week decides the ISO year.
      thursday = count + 3 - count % 7;
      if (jan1_day_count(yr + 1) <= thursday) begin
         iso_yr = yr + 1;
      end else if (jan1_day_count(yr) <= thursday) begin
         iso_yr = yr;
      end else begin
         iso_yr = yr - 1;
      end
      result.week_number = 6'((thursday - jan1_day_count(iso_yr)) / 7 + 1);
      // Years below zero or above the field range wrap modulo 2^14.
      result.iso_year    = 14'(iso_yr - BIAS);
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one date after a random idle gap and returns in the time step of
   // the edge that accepts it. Valid is lowered only when a gap follows, so
   // back-to-back transactions never see valid dropped and raised in one step.
   task automatic send_date(input req_type date);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= date;
      do @(posedge clock); while (req_stall);
      pending_weeks.push_back(iso_week_of(date));
   endtask

   // Mostly well-formed dates, with a strong bias toward the turn of the
   // year where week 53 and the ISO year shift live; the rest is raw bits
   // that exercise month zero, months above twelve, day zero and the years
   // beyond 9999.
   function automatic req_type random_date();
      req_type date;
      int      pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         date.month = 4'($urandom_range(1, 12));
         date.day   = 5'($urandom_range(1, 31));
         date.year  = 14'($urandom_range(1, 9999));
      end else if (pick < 8) begin
         date.year = 14'($urandom_range(1, 9999));
         if ($urandom_range(0, 1) == 1) begin
            date.month = 4'd12;
            date.day   = 5'($urandom_range(20, 31));
         end else begin
            date.month = 4'd1;
            date.day   = 5'($urandom_range(0, 10));
         end
      end else begin
         date.month = 4'($urandom);
         date.day   = 5'($urandom);
         date.year  = 14'($urandom);
      end
      return date;
   endfunction

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // The receiver draws a stall length before every result. A long hold-off
   // requested by a test preempts the random draw, even while it is waiting
   // for a result, so the pipeline fills and the request side backs up.
   initial begin : receiver
      int n;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
         end else begin
            n = $urandom_range(0, rx_gap_max);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock);
         while (!(rsp_valid && !rsp_stall) && hold_cycles == 0);
      end
   end

   // Every accepted result is compared with the oldest prediction. The
   // handshake signals are read at the edge, before any update of that edge.
   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_weeks.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
               $display("unexpected result: week %0d iso_year %0d",
                        rsp_data.week_number, rsp_data.iso_year);
            end
         end else begin
            expected = pending_weeks.pop_front();
            if (rsp_data.week_number !== expected.week_number ||
                rsp_data.iso_year !== expected.iso_year) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS) begin
                  $display("wrong result: expected week %0d iso_year %0d, got week %0d iso_year %0d",
                           expected.week_number, expected.iso_year,
                           rsp_data.week_number, rsp_data.iso_year);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Hand-picked dates: week 53 years, the first ISO week starting in the
   // previous December, leap-year rules of 4, 100 and 400, days rolling past
   // the end of a month, month zero, months above twelve, day zero, and the
   // ISO year wrapping below zero and above the field range.
   task automatic test_directed();
      send_date(req_type'{4'd12, 5'd31, 14'd2020});
      send_date(req_type'{4'd1,  5'd1,  14'd2021});
      send_date(req_type'{4'd1,  5'd4,  14'd2021});
      send_date(req_type'{4'd1,  5'd3,  14'd2010});
      send_date(req_type'{4'd12, 5'd29, 14'd2008});
      send_date(req_type'{4'd12, 5'd31, 14'd2015});
      send_date(req_type'{4'd2,  5'd29, 14'd2000});
      send_date(req_type'{4'd2,  5'd29, 14'd1900});
      send_date(req_type'{4'd3,  5'd1,  14'd2100});
      send_date(req_type'{4'd2,  5'd30, 14'd2024});
      send_date(req_type'{4'd4,  5'd31, 14'd2023});
      send_date(req_type'{4'd12, 5'd31, 14'd9999});
      send_date(req_type'{4'd0,  5'd15, 14'd2021});
      send_date(req_type'{4'd13, 5'd1,  14'd2021});
      send_date(req_type'{4'd15, 5'd31, 14'd16383});
      send_date(req_type'{4'd3,  5'd0,  14'd2024});
      send_date(req_type'{4'd1,  5'd0,  14'd2021});
      send_date(req_type'{4'd1,  5'd1,  14'd0});
      send_date(req_type'{4'd0,  5'd0,  14'd0});
      send_date(req_type'{4'd1,  5'd1,  14'd1});
      send_date(req_type'{4'd12, 5'd31, 14'd16383});
      send_date(req_type'{4'd7,  5'd15, 14'd2024});
      send_date(req_type'{4'd8,  5'd10, 14'd5461});
   endtask

   // Random dates in blocks, each block with its own idling on both sides,
   // including blocks where neither side idles at all.
   task automatic test_random_dates(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) begin
            case ((i / 200) % 4)
               0: begin tx_gap_max = 14; rx_gap_max = 14; end
               1: begin tx_gap_max = 0;  rx_gap_max = 0;  end
               2: begin tx_gap_max = 0;  rx_gap_max = 14; end
               default: begin tx_gap_max = 14; rx_gap_max = 0; end
            endcase
         end
         send_date(random_date());
      end
   endtask

   // The receiver holds off for a long stretch while dates keep coming
   // without gaps; the five stages fill and req_stall must hold the sender
   // without losing or repeating a transaction.
   task automatic test_backpressure();
      tx_gap_max  = 0;
      rx_gap_max  = 3;
      hold_cycles = 120;
      for (int i = 0; i < 40; i++) begin
         send_date(random_date());
      end
      tx_gap_max = 14;
      rx_gap_max = 14;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_dates(1200);
      test_backpressure();
      req_valid <= 1'b0;
      // Let every prediction be answered, then watch a few more cycles for
      // results that should not exist.
      while (pending_weeks.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("iso_week_number_top: match");
      end else begin
         $display("iso_week_number_top: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("iso_week_number_top: mismatch");
      $finish;
   end

endmodule
